FILE: design/gstj_pkg.sv
package gstj_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int DIR_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CELL_W     = 12;
  localparam int DIM_W      = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;
  localparam logic [DIM_W-1:0]      DIM_MIN   = 9'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_JOIN  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_CARVED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OFF_GRID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_JOINED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd4;

endpackage

FILE: design/grid_spanning_tree_joiner_core.sv
// Randomized Kruskal maze carver over a grid of up to MAX_COLS by MAX_ROWS cells. Each
// cell's set label lives in one synchronous memory with a registered read. A start word
// sweeps the whole label store to identity, one entry per cycle. A proposal that carves
// reads both labels and then rescans the grid in use, one cell per cycle through the
// single read port. One word is worked on at a time; a registered output lets the next
// word be accepted while a result waits.
module grid_spanning_tree_joiner_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gstj_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gstj_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic [gstj_pkg::COL_W-1:0]       cell_col_i,
  input  logic [gstj_pkg::ROW_W-1:0]       cell_row_i,
  input  logic [gstj_pkg::DIR_W-1:0]       direction_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gstj_pkg::STATUS_W-1:0]    status_o,
  output logic [gstj_pkg::CELL_W-1:0]      first_cell_o,
  output logic [gstj_pkg::CELL_W-1:0]      second_cell_o,
  output logic [gstj_pkg::CELL_W-1:0]      joins_left_o,
  output logic                             done_res_o
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [gstj_pkg::DIM_W-1:0] MAX_W = gstj_pkg::DIM_W'(MAX_COLS);
  localparam logic [gstj_pkg::DIM_W-1:0] MAX_H = gstj_pkg::DIM_W'(MAX_ROWS);
  localparam logic [IW-1:0] LAST_ENTRY = IW'(DEPTH - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_ADDR     = 4'd2;
  localparam logic [3:0] S_RD_A     = 4'd3;
  localparam logic [3:0] S_RD_B     = 4'd4;
  localparam logic [3:0] S_CMP      = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SCAN_END = 4'd7;
  localparam logic [3:0] S_INIT     = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       pend_q, pend_d;
  logic [IW-1:0] joins_q, joins_d;
  logic [gstj_pkg::CFG_DATA_W-1:0] width_q, height_q;

  logic                           cmd_q, cmd_d;
  logic [gstj_pkg::COL_W-1:0]     col_q, col_d;
  logic [gstj_pkg::ROW_W-1:0]     row_q, row_d;
  logic [gstj_pkg::DIR_W-1:0]     dir_q, dir_d;
  logic [IW-1:0] cells_m1_q, cells_m1_d;
  logic [IW-1:0] here_q, here_d;
  logic [IW-1:0] there_q, there_d;
  logic [IW-1:0] new_lab_q, new_lab_d;
  logic [IW-1:0] old_lab_q, old_lab_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] pend_addr_q, pend_addr_d;
  logic [gstj_pkg::STATUS_W-1:0] res_q, res_d;
  logic [gstj_pkg::STATUS_W-1:0] status_q, status_d;
  logic [gstj_pkg::CELL_W-1:0]   first_q, first_d;
  logic [gstj_pkg::CELL_W-1:0]   second_q, second_d;
  logic [gstj_pkg::CELL_W-1:0]   joins_out_q, joins_out_d;
  logic                          done_q, done_d;

  logic [IW-1:0] label_mem [DEPTH];
  logic [IW-1:0] rdata_q;
  logic          mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  logic [IW-1:0] mem_wr_data;

  logic [gstj_pkg::DIM_W-1:0] w_ext, h_ext, grid_w, grid_h;
  logic [2*gstj_pkg::DIM_W-1:0] cells_prod;
  logic [gstj_pkg::ROW_W+gstj_pkg::DIM_W-1:0] row_prod;
  logic [IW-1:0] w_idx;
  logic in_accept;
  logic off_grid;

  assign w_ext  = gstj_pkg::DIM_W'(width_q);
  assign h_ext  = gstj_pkg::DIM_W'(height_q);
  assign grid_w = (w_ext < gstj_pkg::DIM_MIN) ? gstj_pkg::DIM_MIN :
                  (w_ext > MAX_W) ? MAX_W : w_ext;
  assign grid_h = (h_ext < gstj_pkg::DIM_MIN) ? gstj_pkg::DIM_MIN :
                  (h_ext > MAX_H) ? MAX_H : h_ext;
  assign w_idx  = IW'(grid_w);

  assign cells_prod = (2*gstj_pkg::DIM_W)'(grid_w) * (2*gstj_pkg::DIM_W)'(grid_h);
  assign row_prod   = (gstj_pkg::ROW_W+gstj_pkg::DIM_W)'(row_q)
                    * (gstj_pkg::ROW_W+gstj_pkg::DIM_W)'(grid_w);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    off_grid = (gstj_pkg::DIM_W'(col_q) >= grid_w) || (gstj_pkg::DIM_W'(row_q) >= grid_h);
    case (dir_q)
      gstj_pkg::DIR_DOWN:  off_grid = off_grid ||
                                      (gstj_pkg::DIM_W'(row_q) + 9'd1 >= grid_h);
      gstj_pkg::DIR_LEFT:  off_grid = off_grid || (col_q == '0);
      gstj_pkg::DIR_UP:    off_grid = off_grid || (row_q == '0);
      gstj_pkg::DIR_RIGHT: off_grid = off_grid ||
                                      (gstj_pkg::DIM_W'(col_q) + 9'd1 >= grid_w);
      default:             off_grid = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    joins_d     = joins_q;
    cmd_d       = cmd_q;
    col_d       = col_q;
    row_d       = row_q;
    dir_d       = dir_q;
    cells_m1_d  = cells_m1_q;
    here_d      = here_q;
    there_d     = there_q;
    new_lab_d   = new_lab_q;
    old_lab_d   = old_lab_q;
    idx_d       = idx_q;
    res_d       = res_q;
    status_d    = status_q;
    first_d     = first_q;
    second_d    = second_q;
    joins_out_d = joins_out_q;
    done_d      = done_q;
    pend_d      = (state_q == S_SCAN);
    pend_addr_d = idx_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = pend_addr_q;
    mem_wr_data = new_lab_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (pend_q && (rdata_q == old_lab_q)) begin
      mem_wr_en = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d   = cmd_i;
          col_d   = cell_col_i;
          row_d   = cell_row_i;
          dir_d   = direction_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cells_m1_d = IW'(cells_prod - 18'd1);
        idx_d      = '0;
        if (cmd_q == gstj_pkg::CMD_START) begin
          state_d = S_INIT;
        end else if (joins_q == '0) begin
          res_d   = gstj_pkg::ST_FINISHED;
          state_d = S_EMIT;
        end else if (off_grid) begin
          res_d   = gstj_pkg::ST_OFF_GRID;
          state_d = S_EMIT;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        here_d  = IW'(row_prod + (gstj_pkg::ROW_W+gstj_pkg::DIM_W)'(col_q));
        state_d = S_RD_A;
      end
      S_RD_A: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = here_q;
        case (dir_q)
          gstj_pkg::DIR_DOWN:  there_d = here_q + w_idx;
          gstj_pkg::DIR_LEFT:  there_d = here_q - IW'(1);
          gstj_pkg::DIR_UP:    there_d = here_q - w_idx;
          default:             there_d = here_q + IW'(1);
        endcase
        state_d = S_RD_B;
      end
      S_RD_B: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = there_q;
        new_lab_d   = rdata_q;
        state_d     = S_CMP;
      end
      S_CMP: begin
        old_lab_d = rdata_q;
        idx_d     = '0;
        if (rdata_q == new_lab_q) begin
          res_d   = gstj_pkg::ST_JOINED;
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_q;
        idx_d       = idx_q + IW'(1);
        if (idx_q == cells_m1_q) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        joins_d = joins_q - IW'(1);
        res_d   = gstj_pkg::ST_CARVED;
        state_d = S_EMIT;
      end
      S_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_q;
        mem_wr_data = idx_q;
        idx_d       = idx_q + IW'(1);
        if (idx_q == LAST_ENTRY) begin
          joins_d = cells_m1_q;
          res_d   = gstj_pkg::ST_STARTED;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          if (res_q == gstj_pkg::ST_CARVED) begin
            first_d  = gstj_pkg::CELL_W'(here_q);
            second_d = gstj_pkg::CELL_W'(there_q);
          end else begin
            first_d  = '0;
            second_d = '0;
          end
          joins_out_d = gstj_pkg::CELL_W'(joins_q);
          done_d      = (joins_q == '0);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      joins_q     <= '0;
      width_q     <= gstj_pkg::DIM_RESET;
      height_q    <= gstj_pkg::DIM_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      joins_q     <= joins_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gstj_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_data_i;
          gstj_pkg::CFG_GRID_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    col_q       <= col_d;
    row_q       <= row_d;
    dir_q       <= dir_d;
    cells_m1_q  <= cells_m1_d;
    here_q      <= here_d;
    there_q     <= there_d;
    new_lab_q   <= new_lab_d;
    old_lab_q   <= old_lab_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
    status_q    <= status_d;
    first_q     <= first_d;
    second_q    <= second_d;
    joins_out_q <= joins_out_d;
    done_q      <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      label_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rdata_q <= label_mem[mem_rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign first_cell_o  = first_q;
  assign second_cell_o = second_q;
  assign joins_left_o  = joins_out_q;
  assign done_res_o    = done_q;

`ifndef ASSERT_OFF
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_wr_en)
    else $error("label store written while idle");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted word not decoded");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= cells_m1_q))
    else $error("relabel scan ran past the grid");

  a_joins_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INIT) |=> (joins_q <= $past(joins_q)))
    else $error("join count grew outside a start sweep");
`endif

endmodule
